FILE: rtl/core/sof_length_checksum_frame_parser_assert.svh
// Assertion macros used by the frame parser's result sequencer.
// Expects signals named clk and rst_n in the including module's scope.
`ifndef SOF_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH
`define SOF_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define SLCFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define SLCFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/slcfp_pkg.sv
// Shared types and constants for the frame parser.
// No dependencies; imported by the parser, the result sequencer and the top level.
package slcfp_pkg;

  localparam int MAX_LENGTH_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 1'd1;

  localparam logic [31:0] TIMEOUT_RST = 32'd50;
  localparam logic [7:0]  START_RST   = 8'hAA;

  localparam logic [2:0] ST_RECEIVING = 3'd0;
  localparam logic [2:0] ST_FRAME_OK  = 3'd1;
  localparam logic [2:0] ST_CSUM_ERR  = 3'd2;
  localparam logic [2:0] ST_TIMEOUT   = 3'd3;
  localparam logic [2:0] ST_LEN_ERR   = 3'd4;

  // One pending response from the byte parser to the result sequencer.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] command;
    logic [4:0] frame_length;
    logic       burst;        // good frame with payload: drain the payload store
  } job_t;

endpackage

FILE: rtl/core/slcfp_payload_ram.sv
// Payload store: one write port, one read port, registered read data.
// Depends on nothing; contents are undefined until written.
module slcfp_payload_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/slcfp_parser.sv
// Byte parser: config registers, gap timeout, frame state machine, payload writes.
// Depends on slcfp_pkg; emits one job per accepted byte.
module slcfp_parser #(
  parameter int MAX_LENGTH = slcfp_pkg::MAX_LENGTH_DEF,
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [slcfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slcfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             byte_accept,
  input  logic [7:0]                       data_byte,
  input  logic [31:0]                      arrival_time,
  output slcfp_pkg::job_t                  job,
  output logic [CW-1:0]                    job_count,
  output logic                             wr_en,
  output logic [AW-1:0]                    wr_addr,
  output logic [7:0]                       wr_data
);

  import slcfp_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] timeout_r, timeout_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [7:0]  held_command_r, held_command_nxt;
  logic [CW-1:0] held_length_r, held_length_nxt;
  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;
  logic [31:0] previous_time_r, previous_time_nxt;
  logic        time_seen_r, time_seen_nxt;

  logic [31:0] gap;
  logic        timed_out;
  logic [CW-1:0] count_inc;

  assign gap       = arrival_time - previous_time_r;
  assign timed_out = time_seen_r && (gap > timeout_r);
  assign count_inc = CW'(byte_count_r + 1'b1);

  assign wr_addr = byte_count_r[AW-1:0];
  assign wr_data = data_byte;

  always_comb begin
    phase_nxt         = phase_r;
    timeout_nxt       = timeout_r;
    start_nxt         = start_r;
    held_command_nxt  = held_command_r;
    held_length_nxt   = held_length_r;
    byte_count_nxt    = byte_count_r;
    running_xor_nxt   = running_xor_r;
    previous_time_nxt = previous_time_r;
    time_seen_nxt     = time_seen_r;
    job               = '{status: ST_RECEIVING, command: 8'd0, frame_length: 5'd0,
                          burst: 1'b0};
    job_count         = '0;
    wr_en             = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_nxt = cfg_data;
        CFG_START:   start_nxt   = cfg_data[7:0];
        default: ;
      endcase
    end

    if (byte_accept) begin
      previous_time_nxt = arrival_time;
      if (timed_out) begin
        // drop the byte and hunt for a new start
        phase_nxt  = PH_WAIT;
        job.status = ST_TIMEOUT;
      end else begin
        time_seen_nxt = 1'b1;
        unique case (phase_r)
          PH_WAIT: begin
            if (data_byte == start_r) begin
              phase_nxt       = PH_CMD;
              running_xor_nxt = 8'd0;
              byte_count_nxt  = '0;
            end
          end
          PH_CMD: begin
            held_command_nxt = data_byte;
            running_xor_nxt  = running_xor_r ^ data_byte;
            phase_nxt        = PH_LEN;
          end
          PH_LEN: begin
            running_xor_nxt = running_xor_r ^ data_byte;
            byte_count_nxt  = '0;
            if ({1'b0, data_byte} > 9'(MAX_LENGTH)) begin
              phase_nxt       = PH_WAIT;
              held_length_nxt = '0;
              job.status      = ST_LEN_ERR;
              job.command     = held_command_r;
            end else begin
              held_length_nxt = CW'(data_byte);
              phase_nxt       = (data_byte == 8'd0) ? PH_CHECK : PH_DATA;
            end
          end
          PH_DATA: begin
            wr_en           = 1'b1;
            byte_count_nxt  = count_inc;
            running_xor_nxt = running_xor_r ^ data_byte;
            if (count_inc >= held_length_r) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            phase_nxt   = PH_WAIT;
            job.command = held_command_r;
            if (running_xor_r == data_byte) begin
              job.status = ST_FRAME_OK;
              if (held_length_r != '0) begin
                job.frame_length = 5'(held_length_r);
                job.burst        = 1'b1;
                job_count        = held_length_r;
              end
            end else begin
              job.status       = ST_CSUM_ERR;
              job.frame_length = 5'(held_length_r);
            end
          end
          default: phase_nxt = PH_WAIT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_WAIT;
      timeout_r       <= TIMEOUT_RST;
      start_r         <= START_RST;
      held_command_r  <= 8'd0;
      held_length_r   <= '0;
      byte_count_r    <= '0;
      running_xor_r   <= 8'd0;
      previous_time_r <= 32'd0;
      time_seen_r     <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      timeout_r       <= timeout_nxt;
      start_r         <= start_nxt;
      held_command_r  <= held_command_nxt;
      held_length_r   <= held_length_nxt;
      byte_count_r    <= byte_count_nxt;
      running_xor_r   <= running_xor_nxt;
      previous_time_r <= previous_time_nxt;
      time_seen_r     <= time_seen_nxt;
    end
  end

endmodule

FILE: rtl/core/slcfp_emitter.sv
// Result sequencer: holds one pending job, drains the payload store, output register.
// Depends on slcfp_pkg and the assertion macros header.
`include "sof_length_checksum_frame_parser_assert.svh"

module slcfp_emitter #(
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_in_valid,
  input  slcfp_pkg::job_t job_in,
  input  logic [CW-1:0]   job_in_count,
  output logic            job_pending,
  output logic            rd_en,
  output logic [AW-1:0]   rd_addr,
  input  logic [7:0]      rd_data,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      out_status,
  output logic [7:0]      out_command,
  output logic [4:0]      out_frame_length,
  output logic [7:0]      out_payload_byte,
  output logic [3:0]      out_payload_index,
  output logic            out_last
);

  import slcfp_pkg::*;

  typedef enum logic {
    EM_IDLE,
    EM_SEND
  } em_state_t;

  em_state_t     state_r, state_nxt;
  logic          job_valid_r, job_valid_nxt;
  job_t          job_r, job_nxt;
  logic [CW-1:0] job_count_r, job_count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [7:0]    command_r, command_nxt;
  logic [4:0]    length_r, length_nxt;
  logic [7:0]    pbyte_r, pbyte_nxt;
  logic [3:0]    pindex_r, pindex_nxt;
  logic          last_r, last_nxt;

  logic          slot_free;
  logic          last_hit;

  assign slot_free = !out_valid_r || !out_stall;
  assign last_hit  = (CW'(idx_r) + 1'b1) == job_count_r;

  always_comb begin
    state_nxt     = state_r;
    job_valid_nxt = job_valid_r;
    job_nxt       = job_r;
    job_count_nxt = job_count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    command_nxt   = command_r;
    length_nxt    = length_r;
    pbyte_nxt     = pbyte_r;
    pindex_nxt    = pindex_r;
    last_nxt      = last_r;
    rd_en         = 1'b0;
    rd_addr       = '0;

    if (job_in_valid) begin
      job_valid_nxt = 1'b1;
      job_nxt       = job_in;
      job_count_nxt = job_in_count;
    end

    unique case (state_r)
      EM_IDLE: begin
        if (job_valid_r) begin
          if (job_r.burst) begin
            // prime the read of the first payload entry
            rd_en     = 1'b1;
            idx_nxt   = '0;
            state_nxt = EM_SEND;
          end else if (slot_free) begin
            out_valid_nxt = 1'b1;
            status_nxt    = job_r.status;
            command_nxt   = job_r.command;
            length_nxt    = job_r.frame_length;
            pbyte_nxt     = 8'd0;
            pindex_nxt    = 4'd0;
            last_nxt      = 1'b1;
            job_valid_nxt = 1'b0;
          end
        end
      end
      EM_SEND: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = job_r.status;
          command_nxt   = job_r.command;
          length_nxt    = job_r.frame_length;
          pbyte_nxt     = rd_data;
          pindex_nxt    = 4'(idx_r);
          last_nxt      = last_hit;
          if (last_hit) begin
            job_valid_nxt = 1'b0;
            state_nxt     = EM_IDLE;
          end else begin
            // overlap the next read with this load
            rd_en   = 1'b1;
            rd_addr = AW'(idx_r + 1'b1);
            idx_nxt = AW'(idx_r + 1'b1);
          end
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
      job_r       <= job_nxt;
      job_count_r <= job_count_nxt;
      idx_r       <= idx_nxt;
      status_r    <= status_nxt;
      command_r   <= command_nxt;
      length_r    <= length_nxt;
      pbyte_r     <= pbyte_nxt;
      pindex_r    <= pindex_nxt;
      last_r      <= last_nxt;
    end
  end

  assign job_pending       = job_valid_r;
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_command       = command_r;
  assign out_frame_length  = length_r;
  assign out_payload_byte  = pbyte_r;
  assign out_payload_index = pindex_r;
  assign out_last          = last_r;

  `SLCFP_ASSERT_IMP(a_no_overwrite, job_in_valid, !job_valid_r, "job written while pending")
  `SLCFP_ASSERT_NXT(a_job_taken, job_in_valid, job_valid_r, "accepted job not held")
  `SLCFP_ASSERT_IMP(a_send_burst, state_r == EM_SEND, job_valid_r && job_r.burst,
                    "drain without a burst job")
  `SLCFP_ASSERT_IMP(a_idx_range, state_r == EM_SEND, CW'(idx_r) < job_count_r,
                    "payload index past frame length")
  `SLCFP_ASSERT_IMP(a_mid_burst, out_valid_r && !last_r, state_r == EM_SEND,
                    "non-final result outside a drain")

endmodule

FILE: rtl/core/sof_length_checksum_frame_parser.sv
// Top level of the start/length/XOR-checksum frame parser.
// Depends on slcfp_pkg, slcfp_parser, slcfp_emitter and slcfp_payload_ram.
//
// Takes one received byte per input transaction, each with a 32-bit arrival
// timestamp, and parses frames laid out as start byte, command, length,
// payload and an XOR checksum over command, length and payload. Every byte
// yields at least one result transaction: status 0 while hunting or in a
// frame, 3 when the gap to the previous byte exceeds timeout_ticks (the
// byte is dropped and the parser hunts for a start byte), 4 for a length
// above MAX_LENGTH, 2 for a checksum mismatch, and 1 for a good frame, which
// yields one result per payload byte (or a single result for an empty
// frame); last marks the final result of each input transaction. Payload
// bytes are kept in a one-read, one-write synchronous store of MAX_LENGTH
// entries that needs no clearing after reset; the store is only read after
// the current frame has written it. Timing: each accepted byte's job is
// registered in the job slot and loaded from there into the output register
// once the output is free; no new byte is taken while the slot holds a job.
// Results queue behind one pending entry, so in_stall rises only while that
// entry is occupied. A good frame keeps in_stall high until its last payload
// result is loaded: the store's registered read port delivers one entry per
// cycle while the output is not stalled. Configuration writes (cfg_ready is
// always high) are taken in any cycle and must only be issued while the
// block is idle.
module sof_length_checksum_frame_parser #(
  parameter int MAX_LENGTH = slcfp_pkg::MAX_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  input  logic [31:0]                      in_arrival_time,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_status,
  output logic [7:0]                       out_command,
  output logic [4:0]                       out_frame_length,
  output logic [7:0]                       out_payload_byte,
  output logic [3:0]                       out_payload_index,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slcfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slcfp_pkg::CFG_DATA_W-1:0] cfg_data
);

  import slcfp_pkg::*;

  // Store address width and a count width able to hold MAX_LENGTH itself.
  localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CW = $clog2(MAX_LENGTH + 1);

  logic          byte_accept;
  job_t          job;
  logic [CW-1:0] job_count;
  logic          job_pending;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Take a byte whenever no earlier result is still waiting in the job slot.
  assign in_stall    = job_pending;
  assign byte_accept = in_valid && !in_stall;
  assign cfg_ready   = 1'b1;

  slcfp_parser #(
    .MAX_LENGTH (MAX_LENGTH),
    .AW         (AW),
    .CW         (CW)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_accept  (byte_accept),
    .data_byte    (in_data_byte),
    .arrival_time (in_arrival_time),
    .job          (job),
    .job_count    (job_count),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  // Payload store: written while payload bytes arrive, drained on a good frame.
  slcfp_payload_ram #(
    .DEPTH (MAX_LENGTH),
    .AW    (AW)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold the pending job; feed the output one result per cycle unless stalled.
  slcfp_emitter #(
    .AW (AW),
    .CW (CW)
  ) u_emitter (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_in_valid      (byte_accept),
    .job_in            (job),
    .job_in_count      (job_count),
    .job_pending       (job_pending),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_command       (out_command),
    .out_frame_length  (out_frame_length),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_last          (out_last)
  );

endmodule

FILE: sim/sof_length_checksum_frame_parser_test.sv
// Self-checking testbench for the start/length/XOR-checksum frame parser.
// Depends on slcfp_pkg and sof_length_checksum_frame_parser; a small tracker
// class predicts every result transaction and checks the output stream.
`timescale 1ns / 100ps

module sof_length_checksum_frame_parser_test;
  import slcfp_pkg::*;

  localparam int MAX_LEN = MAX_LENGTH_DEF;
  // Well above the slowest legal run (all idling phases, full bursts).
  localparam longint RUN_LIMIT_NS = 2_000_000;
  localparam int TAIL_CYCLES = 20;

  typedef enum logic [2:0] {
    HUNT_START,
    TAKE_COMMAND,
    TAKE_LENGTH,
    TAKE_PAYLOAD,
    TAKE_CHECKSUM
  } parse_phase_e;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] command;
    logic [4:0] frame_length;
    logic [7:0] payload_byte;
    logic [3:0] payload_index;
    logic       last;
  } parser_result_t;

  // Tracks the parser state, queues the result transactions that each
  // accepted byte must cause, and compares what the block produces.
  class frame_parse_tracker;
    logic [31:0]    timeout_ticks;
    logic [7:0]     start_byte;
    parse_phase_e   phase;
    logic [7:0]     held_command;
    logic [4:0]     held_length;
    logic [4:0]     byte_count;
    logic [7:0]     running_xor;
    logic [31:0]    previous_time;
    bit             time_seen;
    logic [7:0]     payload_store [MAX_LEN];
    parser_result_t pending_results [$];
    int             mismatch_count;
    int             results_checked;
    int             bytes_seen;
    int             outcome_tally [8];

    function new();
      timeout_ticks = TIMEOUT_RST;
      start_byte = START_RST;
      phase = HUNT_START;
      held_command = '0;
      held_length = '0;
      byte_count = '0;
      running_xor = '0;
      previous_time = '0;
      time_seen = 1'b0;
      mismatch_count = 0;
      results_checked = 0;
      bytes_seen = 0;
      foreach (outcome_tally[k]) outcome_tally[k] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_TIMEOUT) timeout_ticks = data;
      else if (idx == CFG_START) start_byte = data[7:0];
    endfunction

    function void push_result(logic [2:0] st, logic [7:0] cmd, logic [4:0] len,
                              logic [7:0] pb, logic [3:0] pi, logic lst);
      parser_result_t r;
      r = '{status: st, command: cmd, frame_length: len, payload_byte: pb,
            payload_index: pi, last: lst};
      pending_results.push_back(r);
      if (lst) outcome_tally[st]++;
    endfunction

    // Advance the parser by one accepted byte and queue what it causes.
    function void predict_byte(logic [7:0] b, logic [31:0] t);
      logic [31:0] gap;
      int i;
      bytes_seen++;
      gap = t - previous_time;
      // Timeout check applies in every phase, but only once a byte was seen.
      // The dropped byte still records its time.
      if (time_seen && gap > timeout_ticks) begin
        phase = HUNT_START;
        previous_time = t;
        push_result(ST_TIMEOUT, 8'h00, 5'd0, 8'h00, 4'd0, 1'b1);
        return;
      end
      previous_time = t;
      time_seen = 1'b1;

      case (phase)
        HUNT_START: begin
          if (b == start_byte) begin
            phase = TAKE_COMMAND;
            running_xor = '0;
            byte_count = '0;
          end
        end
        TAKE_COMMAND: begin
          held_command = b;
          running_xor ^= b;
          phase = TAKE_LENGTH;
        end
        TAKE_LENGTH: begin
          running_xor ^= b;
          byte_count = '0;
          if (b > MAX_LEN) begin
            // Reject instead of overflowing the payload store.
            phase = HUNT_START;
            held_length = '0;
            push_result(ST_LEN_ERR, held_command, 5'd0, 8'h00, 4'd0, 1'b1);
            return;
          end
          held_length = b[4:0];
          phase = (b == 8'd0) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
        end
        TAKE_PAYLOAD: begin
          payload_store[byte_count] = b;
          byte_count++;
          running_xor ^= b;
          if (byte_count >= held_length) phase = TAKE_CHECKSUM;
        end
        TAKE_CHECKSUM: begin
          phase = HUNT_START;
          if (running_xor == b) begin
            if (held_length == 5'd0) begin
              // Empty frame: one good-frame result with no payload.
              push_result(ST_FRAME_OK, held_command, 5'd0, 8'h00, 4'd0, 1'b1);
            end else begin
              for (i = 0; i < held_length; i++)
                push_result(ST_FRAME_OK, held_command, held_length, payload_store[i],
                            4'(i), logic'(i + 1 == held_length));
            end
          end else begin
            push_result(ST_CSUM_ERR, held_command, held_length, 8'h00, 4'd0, 1'b1);
          end
          return;
        end
        default: phase = HUNT_START;
      endcase
      push_result(ST_RECEIVING, 8'h00, 5'd0, 8'h00, 4'd0, 1'b1);
    endfunction

    task report_mismatch(string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatch_count++;
    endtask

    task check_result(parser_result_t got);
      parser_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (status %0d)", got.status));
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.command !== want.command)
        report_mismatch($sformatf("command got %h want %h", got.command, want.command));
      if (got.frame_length !== want.frame_length)
        report_mismatch($sformatf("frame_length got %0d want %0d",
                                  got.frame_length, want.frame_length));
      if (got.payload_byte !== want.payload_byte)
        report_mismatch($sformatf("payload_byte got %h want %h",
                                  got.payload_byte, want.payload_byte));
      if (got.payload_index !== want.payload_index)
        report_mismatch($sformatf("payload_index got %0d want %0d",
                                  got.payload_index, want.payload_index));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %b want %b", got.last, want.last));
    endtask
  endclass

  // ---------------------------------------------------------------------
  // Block ports; every input starts at a known value.
  // ---------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = '0;
  logic [31:0]           in_arrival_time = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_status;
  logic [7:0]            out_command;
  logic [4:0]            out_frame_length;
  logic [7:0]            out_payload_byte;
  logic [3:0]            out_payload_index;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_parse_tracker tracker;

  // Idle rates, in percent of cycles, for the sending and receiving sides.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Local copies of the registers, used to shape timestamps and frames.
  logic [31:0] cur_timeout = TIMEOUT_RST;
  logic [7:0]  cur_start = START_RST;
  logic [31:0] clock_ms = '0;
  int          items_sent = 0;

  sof_length_checksum_frame_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_arrival_time   (in_arrival_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_command       (out_command),
    .out_frame_length  (out_frame_length),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check every accepted transaction with the values sampled at
  // the edge, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(parser_result_t'({out_status, out_command, out_frame_length,
                                             out_payload_byte, out_payload_index,
                                             out_last}));
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Pick the gap to the next byte. Clean gaps never exceed the timeout (and
  // hit it exactly now and then); noisy ones often exceed it or are random.
  function automatic logic [31:0] pick_gap(bit clean);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!clean && roll < 30) begin
      if (roll < 20 && cur_timeout != 32'hFFFF_FFFF)
        return cur_timeout + 32'd1 +
               ((cur_timeout > 32'hFFFF_0000) ? 32'd0 : 32'($urandom_range(0, 100)));
      return $urandom;
    end
    if (roll >= 90) return cur_timeout;
    return $urandom_range(0, (cur_timeout < 32'd40) ? cur_timeout : 32'd40);
  endfunction

  // Offer one byte, advance the timestamp by gap, and hold the transaction
  // until it is taken. Valid stays high on exit so back-to-back bytes do not
  // toggle it; idle cycles lower it one step at a time.
  task automatic send_byte(input logic [7:0] b, input logic [31:0] gap);
    clock_ms = clock_ms + gap;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_arrival_time <= clock_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.predict_byte(b, clock_ms);
    items_sent++;
  endtask

  // Hold off the sender until every predicted result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.write_reg(idx, data);
    if (idx == CFG_TIMEOUT) cur_timeout = data;
    else cur_start = data[7:0];
    @(posedge clk);
  endtask

  // Send a frame with random payload. A length above the store size sends
  // only the header; keep cuts the frame short to leave it broken.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input bit bad_csum, input bit clean, input int keep);
    logic [7:0] frame_bytes [$];
    logic [7:0] csum;
    logic [7:0] pay;
    int k;
    frame_bytes = {cur_start, cmd, len};
    csum = cmd ^ len;
    if (len <= MAX_LEN) begin
      for (k = 0; k < len; k++) begin
        pay = 8'($urandom);
        frame_bytes.push_back(pay);
        csum ^= pay;
      end
      if (bad_csum) csum ^= 8'($urandom_range(1, 255));
      frame_bytes.push_back(csum);
    end
    for (k = 0; k < frame_bytes.size() && k < keep; k++)
      send_byte(frame_bytes[k], pick_gap(clean));
  endtask

  // Mostly well-formed frames with random content; the rest are length
  // errors, truncated frames and bursts of noise bytes.
  task automatic random_traffic(input int count);
    int target;
    int unsigned roll;
    int unsigned len_roll;
    logic [7:0] len;
    int k;
    target = items_sent + count;
    while (items_sent < target) begin
      roll = $urandom_range(0, 99);
      len_roll = $urandom_range(0, 99);
      len = (len_roll < 15) ? 8'(MAX_LEN) :
            (len_roll < 30) ? 8'd0 : 8'($urandom_range(1, MAX_LEN - 1));
      if (roll < 70) begin
        send_frame(8'($urandom), len, $urandom_range(0, 99) < 20,
                   $urandom_range(0, 99) < 90, 255);
      end else if (roll < 80) begin
        send_frame(8'($urandom), 8'($urandom_range(MAX_LEN + 1, 255)), 1'b0, 1'b1, 255);
      end else if (roll < 88) begin
        send_frame(8'($urandom), len, 1'b0, 1'b1, $urandom_range(1, len + 3));
      end else begin
        for (k = $urandom_range(1, 4); k > 0; k--)
          send_byte(($urandom_range(0, 99) < 20) ? cur_start : 8'($urandom), pick_gap(1'b0));
      end
    end
  endtask

  // Directed opening under reset settings: first byte far from time zero,
  // an empty frame across the timestamp wrap, a start byte on a gap equal
  // to the timeout, a length error, a checksum error, a good frame with
  // extreme bytes, and timeouts both inside a frame and while hunting.
  task automatic directed_bytes();
    clock_ms = 32'hFFFF_FFF0;
    send_byte(8'h00, 32'd0);
    send_byte(8'hAA, 32'd5);
    send_byte(8'h00, 32'd5);
    send_byte(8'h00, 32'd5);
    send_byte(8'h00, 32'd5);
    send_byte(8'hAA, 32'd50);
    send_byte(8'h5A, 32'd0);
    send_byte(8'hFF, 32'd1);
    send_byte(8'hAA, 32'd2);
    send_byte(8'hC3, 32'd3);
    send_byte(8'h01, 32'd4);
    send_byte(8'h7E, 32'd5);
    send_byte(8'h43, 32'd6);
    send_byte(8'hAA, 32'd7);
    send_byte(8'hFF, 32'd8);
    send_byte(8'h02, 32'd9);
    send_byte(8'h00, 32'd10);
    send_byte(8'hFF, 32'd11);
    send_byte(8'h02, 32'd12);
    send_byte(8'hAA, 32'd1);
    send_byte(8'h11, 32'd51);
    // The timed-out byte recorded its time, so no second timeout here.
    send_byte(8'h11, 32'd0);
    send_byte(8'hAA, 32'hFFFF_FFFF);
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily, under reset settings.
    send_idle_pct = 32;
    recv_idle_pct = 87;
    directed_bytes();
    random_traffic(80);
    drain_results();

    // Zero timeout only passes equal timestamps; zero start byte.
    set_reg(CFG_TIMEOUT, 32'h0000_0000);
    set_reg(CFG_START, 32'h0000_0000);
    random_traffic(70);
    drain_results();

    // Swap the idle rates; widest timeout never expires.
    send_idle_pct = 87;
    recv_idle_pct = 32;
    set_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    set_reg(CFG_START, 32'h0000_00FF);
    random_traffic(80);
    drain_results();

    // No idling on either side; random settings, with a mid-phase hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_reg(CFG_TIMEOUT, 32'($urandom_range(1, 2000)));
    set_reg(CFG_START, 32'($urandom_range(0, 255)));
    random_traffic(40);
    drain_results();
    random_traffic(40);
    drain_results();

    set_reg(CFG_TIMEOUT, TIMEOUT_RST);
    set_reg(CFG_START, 32'(START_RST));
    random_traffic(80);
    drain_results();

    // Let any stray result show up before closing.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes and %0d checked results over five register settings",
             tracker.bytes_seen, tracker.results_checked);
    $display("Outcomes: %0d good frames, %0d checksum errors, %0d length errors, %0d timeouts",
             tracker.outcome_tally[ST_FRAME_OK], tracker.outcome_tally[ST_CSUM_ERR],
             tracker.outcome_tally[ST_LEN_ERR], tracker.outcome_tally[ST_TIMEOUT]);
    if (tracker.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/slcfp_pkg.sv
rtl/core/slcfp_payload_ram.sv
rtl/core/slcfp_parser.sv
rtl/core/slcfp_emitter.sv
rtl/core/sof_length_checksum_frame_parser.sv
sim/sof_length_checksum_frame_parser_test.sv
